FILE: hw/rtl/octave_perlin_noise_2d_defines.svh
// Assertion macros used by the checker file of the noise block.
// Depends on nothing; include by bare file name.
`ifndef OCTAVE_PERLIN_NOISE_2D_DEFINES_SVH
`define OCTAVE_PERLIN_NOISE_2D_DEFINES_SVH

// Assert with the check suspended while reset is held.
`define OPN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that also runs during reset.
`define OPN_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/opn_pkg.sv
// Package of the octave Perlin noise block: widths, register codes, types,
// the permutation table and the gradient and interpolation helpers. No dependencies.
package opn_pkg;

  localparam int MaxOctDefault = 8;
  localparam int OctLimit      = 16;
  localparam int FracBits      = 16;
  localparam int Ones          = 65536;
  localparam int CoordW        = 24;
  localparam int OutW          = 16;
  localparam int AmpW          = 17;
  localparam int CntW          = 4;
  localparam int OctNW         = 5;
  localparam int GradW         = FracBits + 2;
  localparam int NoiseW        = FracBits + 3;
  localparam int QW            = 20;
  localparam int WgtW          = AmpW + $clog2(OctLimit);
  localparam int QuotW         = 18;
  localparam int DivW          = WgtW + QuotW;
  localparam int SumW          = DivW + 1;
  localparam int DataW         = 32;
  localparam int PAddrW        = 3;

  // Register indexes (paddr[2]).
  localparam logic RegOctCount = 1'b0;
  localparam logic RegPersist  = 1'b1;

  localparam logic [CntW-1:0] OctCountReset = CntW'(1);
  localparam logic [AmpW-1:0] PersistReset  = AmpW'(32768);
  localparam logic [AmpW-1:0] AmpOne        = AmpW'(Ones);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [AmpW-1:0]   amp;
    logic [WgtW-1:0]   weight;
    logic [SumW-1:0]   sum;
  } opn_carry_t;

  typedef struct packed {
    logic [OctNW-1:0] oct_n;
    logic [AmpW-1:0]  persist;
  } opn_cfg_t;

  localparam logic [7:0] PermRom [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,
    8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,
    8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,
    8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,
    8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,
    8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,
    8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,
    8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,
    8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,
    8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,
    8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,
    8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,
    8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
    8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,
    8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,
    8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,
    8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic signed [NoiseW-1:0] grad_sel(input logic [2:0] h,
                                                       input logic signed [GradW-1:0] gx,
                                                       input logic signed [GradW-1:0] gy);
    logic signed [NoiseW-1:0] ex;
    logic signed [NoiseW-1:0] ey;
    ex = NoiseW'(gx);
    ey = NoiseW'(gy);
    case (h)
      3'd0:    grad_sel = ex + ey;
      3'd1:    grad_sel = ey - ex;
      3'd2:    grad_sel = ex - ey;
      3'd3:    grad_sel = -ex - ey;
      3'd4:    grad_sel = ex;
      3'd5:    grad_sel = -ex;
      3'd6:    grad_sel = ey;
      default: grad_sel = -ey;
    endcase
  endfunction

  // a + floor((b - a) * w / ONE)
  function automatic logic signed [NoiseW-1:0] lerp(input logic signed [NoiseW-1:0] a,
                                                   input logic signed [NoiseW-1:0] b,
                                                   input logic [AmpW-1:0] w);
    logic signed [NoiseW:0]        diff;
    logic signed [NoiseW+AmpW+1:0] prod;
    logic signed [NoiseW+AmpW+1:0] shr;
    diff = NoiseW'(b) - NoiseW'(a);
    diff = (NoiseW+1)'(b) - (NoiseW+1)'(a);
    prod = diff * $signed({1'b0, w});
    shr  = prod >>> FracBits;
    lerp = a + shr[NoiseW-1:0];
  endfunction

endpackage

FILE: hw/rtl/opn_if.sv
// Valid/ready channel interfaces of the noise block: coordinates in, noise out.
// Depends on opn_pkg.
interface opn_in_if import opn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] x_coord;
  logic [CoordW-1:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface opn_out_if import opn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OutW-1:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

FILE: hw/rtl/opn_out_fifo.sv
// Two-entry output queue that decouples the pipeline from the result receiver.
// Depends on opn_pkg.
module opn_out_fifo import opn_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [OutW-1:0] push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [OutW-1:0] out_data
);
  logic [OutW-1:0] mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end
endmodule

FILE: hw/rtl/opn_octave.sv
// One octave segment: six pipeline stages that hash, fade, blend and accumulate
// one octave into the running weighted sum. Depends on opn_pkg.
module opn_octave import opn_pkg::*; #(
  parameter int OCT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  opn_cfg_t   cfg,
  input  logic       in_valid,
  input  opn_carry_t in_carry,
  output logic       out_valid,
  output opn_carry_t out_carry
);
  localparam int ShW = CoordW + OctLimit;

  logic [5:0] vld_r;

  // Stage 1: lattice coordinates, first hash, squares.
  logic [ShW-1:0]        xs, ys;
  logic [7:0]            xi, yi;
  logic [FracBits-1:0]   fx, fy;
  logic [2*FracBits-1:0] fxsq, fysq;
  opn_carry_t            s1_carry_r;
  logic [FracBits-1:0]   s1_fx_r, s1_fy_r, s1_tx2_r, s1_ty2_r;
  logic [7:0]            s1_yi_r, s1_pa_r, s1_pb_r;

  assign xs   = ShW'(in_carry.x) << OCT;
  assign ys   = ShW'(in_carry.y) << OCT;
  assign xi   = xs[FracBits+7:FracBits];
  assign yi   = ys[FracBits+7:FracBits];
  assign fx   = xs[FracBits-1:0];
  assign fy   = ys[FracBits-1:0];
  assign fxsq = fx * fx;
  assign fysq = fy * fy;

  // Stage 2: corner hashes, cubes, fade polynomials.
  logic [2*FracBits-1:0] tx3p, ty3p;
  logic [QW+1:0]         qx, qy;
  logic [7:0]            pay, pby;
  opn_carry_t            s2_carry_r;
  logic [FracBits-1:0]   s2_fx_r, s2_fy_r, s2_tx3_r, s2_ty3_r;
  logic [QW-1:0]         s2_qx_r, s2_qy_r;
  logic [2:0]            s2_aa_r, s2_ba_r, s2_ab_r, s2_bb_r;

  assign tx3p = s1_tx2_r * s1_fx_r;
  assign ty3p = s1_ty2_r * s1_fy_r;
  assign qx   = (QW+2)'(10 * Ones) + (QW+2)'(s1_tx2_r) * (QW+2)'(6)
              - (QW+2)'(s1_fx_r) * (QW+2)'(15);
  assign qy   = (QW+2)'(10 * Ones) + (QW+2)'(s1_ty2_r) * (QW+2)'(6)
              - (QW+2)'(s1_fy_r) * (QW+2)'(15);
  assign pay  = s1_pa_r + s1_yi_r;
  assign pby  = s1_pb_r + s1_yi_r;

  // Stage 3: fade weights and corner gradients.
  logic [FracBits+QW-1:0]   up, vp;
  logic signed [GradW-1:0]  gx0, gx1, gy0, gy1;
  opn_carry_t               s3_carry_r;
  logic [AmpW-1:0]          s3_u_r, s3_v_r;
  logic signed [NoiseW-1:0] s3_gaa_r, s3_gba_r, s3_gab_r, s3_gbb_r;

  assign up  = s2_tx3_r * s2_qx_r;
  assign vp  = s2_ty3_r * s2_qy_r;
  assign gx0 = $signed({2'b00, s2_fx_r});
  assign gy0 = $signed({2'b00, s2_fy_r});
  assign gx1 = gx0 - GradW'(Ones);
  assign gy1 = gy0 - GradW'(Ones);

  // Stage 4: blend along x.
  opn_carry_t               s4_carry_r;
  logic [AmpW-1:0]          s4_v_r;
  logic signed [NoiseW-1:0] s4_r0_r, s4_r1_r;

  // Stage 5: blend along y, octave noise, next amplitude.
  logic signed [NoiseW-1:0] blend5;
  logic [NoiseW:0]          bias5;
  logic [2*AmpW-1:0]        ampp;
  opn_carry_t               s5_carry_r;
  logic signed [NoiseW-1:0] s5_noise_r;
  logic [AmpW-1:0]          s5_amp_r;

  assign blend5 = lerp(s4_r0_r, s4_r1_r, s4_v_r);
  assign bias5  = (NoiseW+1)'(blend5) + (NoiseW+1)'(Ones);
  assign ampp   = s4_carry_r.amp * cfg.persist;

  // Stage 6: accumulate when this octave is enabled.
  logic signed [NoiseW+AmpW:0] prod6;
  logic signed [SumW-1:0]      sum6;
  logic                        active;
  opn_carry_t                  s6_nxt;
  opn_carry_t                  s6_carry_r;

  assign prod6  = s5_noise_r * $signed({1'b0, s5_carry_r.amp});
  assign sum6   = $signed(s5_carry_r.sum) + SumW'(prod6);
  assign active = (OctNW'(OCT) < cfg.oct_n);

  always_comb begin
    s6_nxt = s5_carry_r;
    if (active) begin
      s6_nxt.sum    = sum6;
      s6_nxt.weight = s5_carry_r.weight + WgtW'(s5_carry_r.amp);
      s6_nxt.amp    = s5_amp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_carry_r <= in_carry;
      s1_fx_r    <= fx;
      s1_fy_r    <= fy;
      s1_tx2_r   <= fxsq[2*FracBits-1:FracBits];
      s1_ty2_r   <= fysq[2*FracBits-1:FracBits];
      s1_yi_r    <= yi;
      s1_pa_r    <= PermRom[xi];
      s1_pb_r    <= PermRom[xi + 8'd1];

      s2_carry_r <= s1_carry_r;
      s2_fx_r    <= s1_fx_r;
      s2_fy_r    <= s1_fy_r;
      s2_tx3_r   <= tx3p[2*FracBits-1:FracBits];
      s2_ty3_r   <= ty3p[2*FracBits-1:FracBits];
      s2_qx_r    <= qx[QW-1:0];
      s2_qy_r    <= qy[QW-1:0];
      s2_aa_r    <= PermRom[pay][2:0];
      s2_ab_r    <= PermRom[pay + 8'd1][2:0];
      s2_ba_r    <= PermRom[pby][2:0];
      s2_bb_r    <= PermRom[pby + 8'd1][2:0];

      s3_carry_r <= s2_carry_r;
      s3_u_r     <= up[FracBits+AmpW-1:FracBits];
      s3_v_r     <= vp[FracBits+AmpW-1:FracBits];
      s3_gaa_r   <= grad_sel(s2_aa_r, gx0, gy0);
      s3_gba_r   <= grad_sel(s2_ba_r, gx1, gy0);
      s3_gab_r   <= grad_sel(s2_ab_r, gx0, gy1);
      s3_gbb_r   <= grad_sel(s2_bb_r, gx1, gy1);

      s4_carry_r <= s3_carry_r;
      s4_v_r     <= s3_v_r;
      s4_r0_r    <= lerp(s3_gaa_r, s3_gba_r, s3_u_r);
      s4_r1_r    <= lerp(s3_gab_r, s3_gbb_r, s3_u_r);

      s5_carry_r <= s4_carry_r;
      s5_noise_r <= $signed(bias5[NoiseW:1]);
      s5_amp_r   <= ampp[FracBits+AmpW-1:FracBits];

      s6_carry_r <= s6_nxt;
    end
  end

  assign out_valid = vld_r[5];
  assign out_carry = s6_carry_r;
endmodule

FILE: hw/rtl/opn_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with clamping of
// negative sums and saturation to Q0.16. Depends on opn_pkg.
module opn_divider import opn_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [SumW-1:0] sum_in,
  input  logic [WgtW-1:0] weight_in,
  output logic            out_valid,
  output logic [OutW-1:0] out_value
);
  logic [DivW-1:0]  rem_r [QuotW-1];
  logic [WgtW-1:0]  w_r   [QuotW-1];
  logic [QuotW-1:0] q_r   [QuotW];
  logic             vld_r [QuotW];
  logic [QuotW-1:0] q_last;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int B = QuotW - 1 - k;
    logic [DivW-1:0]  rem_in, sh, rem_nxt;
    logic [QuotW-1:0] q_in, q_nxt;
    logic [WgtW-1:0]  w_in;
    logic             v_in;

    if (k == 0) begin : g_first
      // Drop negative sums to zero: the quotient then comes out zero.
      assign rem_in = sum_in[SumW-1] ? '0 : sum_in[DivW-1:0];
      assign q_in   = '0;
      assign w_in   = weight_in;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign w_in   = w_r[k-1];
      assign v_in   = vld_r[k-1];
    end

    assign sh = DivW'(w_in) << B;

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= sh) begin
        rem_nxt  = rem_in - sh;
        q_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) q_r[k] <= q_nxt;
    end

    if (k < QuotW - 1) begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          w_r[k]   <= w_in;
        end
      end
    end
  end

  assign q_last    = q_r[QuotW-1];
  assign out_valid = vld_r[QuotW-1];
  assign out_value = (|q_last[QuotW-1:OutW]) ? '1 : q_last[OutW-1:0];
endmodule

FILE: hw/rtl/octave_perlin_noise_2d.sv
// Fractal 2-D Perlin noise sampler.
// Channels: in_ch takes one transaction per sample (x_coord, y_coord, unsigned
// Q8.16); out_ch returns one noise_value (unsigned Q0.16) per sample, in order.
// Configuration: APB-style port, octave_count at byte 0, persistence at byte 4;
// pready is tied high and reads return the stored register.
// Throughput: one transaction per cycle, sustained while the output queue is not full.
// Pipeline from input transaction to output valid: six stages per octave
// segment, eighteen divider stages (one quotient bit each), one output queue
// register.
// Every item walks all MAX_OCTAVES segments; segments above octave_count pass
// the running sum through untouched.
// Stall: the whole pipeline holds while the two-entry output queue is full;
// in_ch.ready is low exactly then, so a result waiting alone does not block
// new transactions. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): valid bits and queue clear, registers go to
// octave_count = 1 and persistence = 0.5. Write configuration only while idle.
module octave_perlin_noise_2d import opn_pkg::*; #(
  parameter int MAX_OCTAVES = MaxOctDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  opn_in_if.sink            in_ch,
  opn_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);
  logic [CntW-1:0] octave_count_r;
  logic [AmpW-1:0] persistence_r;
  logic            cfg_wr;
  logic            reg_idx;
  opn_cfg_t        cfg;
  logic            en;
  logic            q_full;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= OctCountReset;
      persistence_r  <= PersistReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegOctCount: octave_count_r <= pwdata[CntW-1:0];
        RegPersist:  persistence_r  <= pwdata[AmpW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOctCount: prdata = DataW'(octave_count_r);
      RegPersist:  prdata = DataW'(persistence_r);
      default:     prdata = '0;
    endcase
  end

  // Clamp the octave count to [1, MAX_OCTAVES] and persistence to 1.0.
  always_comb begin
    cfg.oct_n = OctNW'(octave_count_r);
    if (octave_count_r == '0) cfg.oct_n = OctNW'(1);
    if (OctNW'(octave_count_r) > OctNW'(MAX_OCTAVES)) cfg.oct_n = OctNW'(MAX_OCTAVES);
    cfg.persist = (persistence_r > AmpOne) ? AmpOne : persistence_r;
  end

  // Advance every stage together unless the output queue is full.
  assign en          = !q_full;
  assign in_ch.ready = en;

  logic       seg_valid [MAX_OCTAVES+1];
  opn_carry_t seg_carry [MAX_OCTAVES+1];

  // Seed the running carry: first amplitude is 1.0, nothing summed yet.
  assign seg_valid[0]        = in_ch.valid;
  assign seg_carry[0].x      = in_ch.x_coord;
  assign seg_carry[0].y      = in_ch.y_coord;
  assign seg_carry[0].amp    = AmpOne;
  assign seg_carry[0].weight = '0;
  assign seg_carry[0].sum    = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    opn_octave #(.OCT(i)) u_oct (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cfg      (cfg),
      .in_valid (seg_valid[i]),
      .in_carry (seg_carry[i]),
      .out_valid(seg_valid[i+1]),
      .out_carry(seg_carry[i+1])
    );
  end

  logic            div_valid;
  logic [OutW-1:0] div_value;

  opn_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (seg_valid[MAX_OCTAVES]),
    .sum_in   (seg_carry[MAX_OCTAVES].sum),
    .weight_in(seg_carry[MAX_OCTAVES].weight),
    .out_valid(div_valid),
    .out_value(div_value)
  );

  opn_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (en && div_valid),
    .push_data(div_value),
    .full     (q_full),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_ch.noise_value)
  );
endmodule

FILE: hw/rtl/opn_checker.sv
// Port-level checker for the noise block, attached by bind.
// Depends on opn_pkg, opn_if and octave_perlin_noise_2d_defines.svh.
`include "octave_perlin_noise_2d_defines.svh"

module opn_checker import opn_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  opn_in_if.sink           in_ch,
  opn_out_if.source        out_ch,
  input logic              pready
);
  // A held result stays offered.
  `OPN_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "out valid dropped")
  // A held result keeps its value.
  `OPN_ASSERT(a_out_stable, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(out_ch.noise_value), "out payload changed")
  // With nothing queued at the output, the pipeline must take input.
  `OPN_ASSERT(a_ready_empty, clk, rst_n, !out_ch.valid |-> in_ch.ready && pready, "ready low with empty output")
  // Reset empties the output queue.
  `OPN_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_ch.valid, "output valid after reset")
endmodule

bind octave_perlin_noise_2d opn_checker u_opn_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_ch (in_ch),
  .out_ch(out_ch),
  .pready(pready)
);
